// ===== rtl/core/kmsd_pkg.sv =====
package kmsd_pkg;

    // Default matrix size.
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 16;

    // Field widths.
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int HIST_W     = 8;
    localparam int HOLD_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register reset values.
    localparam logic [HIST_W-1:0] DOWN_THR_RST = 8'd127;
    localparam logic [HIST_W-1:0] UP_THR_RST   = 8'd1;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 4'd10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOWN_THR = 2'd0,
        CFG_UP_THR   = 2'd1,
        CFG_HOLDOFF  = 2'd2
    } t_cfg_reg;

    // One raw key sample.
    typedef struct packed {
        logic [ROW_W-1:0] key_row;
        logic [COL_W-1:0] key_col;
        logic             raw_down;
        logic             scan_end;
    } t_key_item;

    // One result beat.
    typedef struct packed {
        logic key_down;
        logic key_changed;
        logic all_released;
        logic scan_done;
    } t_result;

    // One configuration write beat.
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
    } t_cfg_beat;

    // Per-key state word held in the state memory.
    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic [HOLD_W-1:0] holdoff;
        logic              down;
    } t_key_state;

endpackage

// ===== rtl/core/kmsd_chan_if.sv =====
interface kmsd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== rtl/core/kmsd_ram.sv =====
module kmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/core/key_matrix_shift_debounce.sv =====
// Key matrix debouncer with a shifted sample history per key.
// i_key carries one raw sample of one key per beat (row, column, contact bit and
// an end-of-scan flag). o_res returns exactly one result beat per sample, in order:
// the debounced state, a change flag, and on the end-of-scan beat whether every
// in-range sample of that scan took the release path. i_cfg writes the down
// threshold, the up threshold and the hold-off reload value; it is always ready
// and should be used only while no samples are in flight.
// Per-key state (history, hold-off counter, debounced bit) sits in one memory
// with a registered read. A sample is read in the cycle it is accepted, updated
// and written back from the update stage, and its result lands in the output
// register; one sample per cycle is sustained while the receiver does not stall.
// A write-back register forwards the newest entry when the same key is sampled
// back to back. After reset a clearing pass zeroes the memory, one entry per
// cycle, during which i_key is not ready.
// When the receiver stalls, the result waits in the output register; one more
// sample is taken into the update stage, and i_key then stalls too.
module key_matrix_shift_debounce #(
    parameter int ROWS = kmsd_pkg::ROWS_DEF,
    parameter int COLS = kmsd_pkg::COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmsd_chan_if.sink     i_key,
    kmsd_chan_if.sink     i_cfg,
    kmsd_chan_if.source   o_res
);
    localparam int KEYS   = ROWS * COLS;
    localparam int ADDR_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int ST_W   = $bits(kmsd_pkg::t_key_state);

    // Configuration registers.
    logic [kmsd_pkg::HIST_W-1:0] r_down_thr;
    logic [kmsd_pkg::HIST_W-1:0] r_up_thr;
    logic [kmsd_pkg::HOLD_W-1:0] r_holdoff;

    // Clearing pass.
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // Update stage.
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_inr;
    logic              r_s1_raw;
    logic              r_s1_last;

    // Write-back forwarding.
    logic                  r_fwd_vld;
    logic [ADDR_W-1:0]     r_fwd_addr;
    kmsd_pkg::t_key_state  r_fwd_data;

    // Scan flag and output register.
    logic                r_all_up;
    logic                r_out_vld;
    kmsd_pkg::t_result   r_out;

    logic                  in_accept;
    logic                  s1_adv;
    logic                  s1_wr;
    logic [31:0]           key_lin;
    logic                  key_inr;
    logic [ADDR_W-1:0]     key_idx;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ST_W-1:0]       ram_wdata;
    logic [ST_W-1:0]       ram_rdata;
    kmsd_pkg::t_key_state  cur_state;
    kmsd_pkg::t_key_state  n_state;
    logic                  rel_path;
    logic                  all_up_tmp;
    logic                  n_all_up;
    kmsd_pkg::t_result     n_out;
    logic [kmsd_pkg::HIST_W-1:0] hist;

    // Handshakes.
    assign s1_adv      = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_key.ready = !r_clr_active && (!r_s1_vld || s1_adv);
    assign in_accept   = i_key.valid && i_key.ready;
    assign s1_wr       = s1_adv && r_s1_inr;
    assign i_cfg.ready = 1'b1;

    // Linear key index and matrix bounds check.
    always_comb begin
        key_lin = 32'(i_key.payload.key_row) * 32'(COLS) + 32'(i_key.payload.key_col);
        key_inr = (32'(i_key.payload.key_row) < 32'(ROWS))
               && (32'(i_key.payload.key_col) < 32'(COLS));
        key_idx = key_lin[ADDR_W-1:0];
    end

    // Memory port selection: clearing pass first, then write-back.
    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_wr;
            ram_waddr = r_s1_addr;
            ram_wdata = n_state;
        end
    end

    kmsd_ram #(
        .WIDTH (ST_W),
        .DEPTH (KEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (key_idx),
        .o_rdata (ram_rdata)
    );

    // Debounce update of one key.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_state = r_fwd_data;
        end else begin
            cur_state = kmsd_pkg::t_key_state'(ram_rdata);
        end
        hist             = {r_s1_raw, cur_state.history[kmsd_pkg::HIST_W-1:1]};
        n_state          = cur_state;
        n_state.history  = hist;
        rel_path         = 1'b0;
        if ((cur_state.holdoff != '0) && !cur_state.down) begin
            n_state.holdoff = cur_state.holdoff - kmsd_pkg::HOLD_W'(1);
        end else if (hist > r_down_thr) begin
            n_state.down    = 1'b1;
            n_state.holdoff = r_holdoff;
        end else if (hist < r_up_thr) begin
            n_state.down = 1'b0;
            rel_path     = 1'b1;
        end

        all_up_tmp = (r_s1_inr && !rel_path) ? 1'b0 : r_all_up;
        n_all_up   = r_s1_last ? 1'b1 : all_up_tmp;

        n_out.key_down     = r_s1_inr && n_state.down;
        n_out.key_changed  = r_s1_inr && (n_state.down != cur_state.down);
        n_out.all_released = r_s1_last && all_up_tmp;
        n_out.scan_done    = r_s1_last;
    end

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_thr <= kmsd_pkg::DOWN_THR_RST;
            r_up_thr   <= kmsd_pkg::UP_THR_RST;
            r_holdoff  <= kmsd_pkg::HOLDOFF_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_index)
                kmsd_pkg::CFG_DOWN_THR: begin
                    r_down_thr <= i_cfg.payload.reg_value;
                end
                kmsd_pkg::CFG_UP_THR: begin
                    r_up_thr <= i_cfg.payload.reg_value;
                end
                kmsd_pkg::CFG_HOLDOFF: begin
                    r_holdoff <= i_cfg.payload.reg_value[kmsd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == ADDR_W'(KEYS - 1)) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Update stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Update stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr <= key_idx;
            r_s1_inr  <= key_inr;
            r_s1_raw  <= i_key.payload.raw_down;
            r_s1_last <= i_key.payload.scan_end;
        end
    end

    // Forwarding register holds the newest write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (s1_wr) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_state;
        end
    end

    // Scan-wide release flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_up <= 1'b1;
        end else if (s1_adv) begin
            r_all_up <= n_all_up;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    // No sample enters while the memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !in_accept)
        else $error("sample accepted during clearing pass");

    // The clearing pass ends only after the last entry.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> ($past(r_clr_addr) == ADDR_W'(KEYS - 1)))
        else $error("clearing pass ended early");

    // A stalled update stage keeps its sample.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_addr) && $stable(r_s1_last)))
        else $error("update stage lost a stalled sample");

    // A release report appears only on an end-of-scan beat.
    a_report_on_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.all_released) |-> r_out.scan_done)
        else $error("release report outside end of scan");

endmodule
